/* hdl/tac_pkg.sv */
// Package for touch affine calibration: transaction types, codes and the solve/map microprogram.
`default_nettype none
package tac_pkg;

  localparam int ACC_W = 128;
  localparam int MIN_POINTS = 3;
  localparam logic [5:0] MAP_START = 6'd33;

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_SOLVE = 2'd1,
    REQ_MAP   = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    RK_MAP  = 2'd0,
    RK_COEF = 2'd1,
    RK_ERR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_FEW      = 2'd1,
    ERR_SINGULAR = 2'd2,
    ERR_OVERFLOW = 2'd3
  } err_t;

  localparam logic [0:0] REG_WIDTH  = 1'd0;
  localparam logic [0:0] REG_HEIGHT = 1'd1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [11:0] raw_x;
    logic [11:0] raw_y;
    logic [10:0] target_x;
    logic [10:0] target_y;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic [1:0]         error_code;
    logic [10:0]        mapped_x;
    logic [10:0]        mapped_y;
    logic [2:0]         coef_index;
    logic signed [31:0] coef_value;
    logic               last;
  } out_item_t;

  // adjugate entries, symmetric matrix
  localparam logic [2:0] ADJ_00 = 3'd0;
  localparam logic [2:0] ADJ_01 = 3'd1;
  localparam logic [2:0] ADJ_02 = 3'd2;
  localparam logic [2:0] ADJ_11 = 3'd3;
  localparam logic [2:0] ADJ_12 = 3'd4;
  localparam logic [2:0] ADJ_22 = 3'd5;

  typedef enum logic [4:0] {
    SRC_ZERO, SRC_A, SRC_B, SRC_C, SRC_D, SRC_E, SRC_N,
    SRC_BX0, SRC_BX1, SRC_BX2, SRC_BY0, SRC_BY1, SRC_BY2,
    SRC_ADJ, SRC_COEF, SRC_RX, SRC_RY, SRC_ONE
  } src_t;

  typedef enum logic [2:0] {
    DST_ACC, DST_ADJ, DST_DET, DST_DIV, DST_MAPX, DST_MAPY
  } dst_t;

  typedef struct packed {
    src_t       mc;
    logic [2:0] mc_idx;
    src_t       mp;
    logic       neg;
    logic       first;
    dst_t       dst;
    logic [2:0] dst_idx;
  } prog_t;

  function automatic prog_t ent(src_t mc, logic [2:0] mci, src_t mp, logic neg,
                                logic first, dst_t dst, logic [2:0] di);
    prog_t p;
    p.mc = mc;
    p.mc_idx = mci;
    p.mp = mp;
    p.neg = neg;
    p.first = first;
    p.dst = dst;
    p.dst_idx = di;
    return p;
  endfunction

  // Each step is acc (+/-)= mcand * mplier; a destination other than DST_ACC closes a sum.
  function automatic prog_t prog_step(logic [5:0] s);
    prog_t p;
    p = ent(SRC_ZERO, 3'd0, SRC_ZERO, 1'b0, 1'b1, DST_ACC, 3'd0);
    unique case (s)
      6'd0:  p = ent(SRC_D, 3'd0, SRC_N, 1'b0, 1'b1, DST_ACC, 3'd0);
      6'd1:  p = ent(SRC_E, 3'd0, SRC_E, 1'b1, 1'b0, DST_ADJ, ADJ_00);
      6'd2:  p = ent(SRC_C, 3'd0, SRC_E, 1'b0, 1'b1, DST_ACC, 3'd0);
      6'd3:  p = ent(SRC_B, 3'd0, SRC_N, 1'b1, 1'b0, DST_ADJ, ADJ_01);
      6'd4:  p = ent(SRC_B, 3'd0, SRC_E, 1'b0, 1'b1, DST_ACC, 3'd0);
      6'd5:  p = ent(SRC_D, 3'd0, SRC_C, 1'b1, 1'b0, DST_ADJ, ADJ_02);
      6'd6:  p = ent(SRC_A, 3'd0, SRC_N, 1'b0, 1'b1, DST_ACC, 3'd0);
      6'd7:  p = ent(SRC_C, 3'd0, SRC_C, 1'b1, 1'b0, DST_ADJ, ADJ_11);
      6'd8:  p = ent(SRC_B, 3'd0, SRC_C, 1'b0, 1'b1, DST_ACC, 3'd0);
      6'd9:  p = ent(SRC_A, 3'd0, SRC_E, 1'b1, 1'b0, DST_ADJ, ADJ_12);
      6'd10: p = ent(SRC_A, 3'd0, SRC_D, 1'b0, 1'b1, DST_ACC, 3'd0);
      6'd11: p = ent(SRC_B, 3'd0, SRC_B, 1'b1, 1'b0, DST_ADJ, ADJ_22);
      6'd12: p = ent(SRC_ADJ, ADJ_00, SRC_A, 1'b0, 1'b1, DST_ACC, 3'd0);
      6'd13: p = ent(SRC_ADJ, ADJ_01, SRC_B, 1'b0, 1'b0, DST_ACC, 3'd0);
      6'd14: p = ent(SRC_ADJ, ADJ_02, SRC_C, 1'b0, 1'b0, DST_DET, 3'd0);
      6'd15: p = ent(SRC_ADJ, ADJ_00, SRC_BX0, 1'b0, 1'b1, DST_ACC, 3'd0);
      6'd16: p = ent(SRC_ADJ, ADJ_01, SRC_BX1, 1'b0, 1'b0, DST_ACC, 3'd0);
      6'd17: p = ent(SRC_ADJ, ADJ_02, SRC_BX2, 1'b0, 1'b0, DST_DIV, 3'd0);
      6'd18: p = ent(SRC_ADJ, ADJ_00, SRC_BY0, 1'b0, 1'b1, DST_ACC, 3'd0);
      6'd19: p = ent(SRC_ADJ, ADJ_01, SRC_BY1, 1'b0, 1'b0, DST_ACC, 3'd0);
      6'd20: p = ent(SRC_ADJ, ADJ_02, SRC_BY2, 1'b0, 1'b0, DST_DIV, 3'd3);
      6'd21: p = ent(SRC_ADJ, ADJ_01, SRC_BX0, 1'b0, 1'b1, DST_ACC, 3'd0);
      6'd22: p = ent(SRC_ADJ, ADJ_11, SRC_BX1, 1'b0, 1'b0, DST_ACC, 3'd0);
      6'd23: p = ent(SRC_ADJ, ADJ_12, SRC_BX2, 1'b0, 1'b0, DST_DIV, 3'd1);
      6'd24: p = ent(SRC_ADJ, ADJ_01, SRC_BY0, 1'b0, 1'b1, DST_ACC, 3'd0);
      6'd25: p = ent(SRC_ADJ, ADJ_11, SRC_BY1, 1'b0, 1'b0, DST_ACC, 3'd0);
      6'd26: p = ent(SRC_ADJ, ADJ_12, SRC_BY2, 1'b0, 1'b0, DST_DIV, 3'd4);
      6'd27: p = ent(SRC_ADJ, ADJ_02, SRC_BX0, 1'b0, 1'b1, DST_ACC, 3'd0);
      6'd28: p = ent(SRC_ADJ, ADJ_12, SRC_BX1, 1'b0, 1'b0, DST_ACC, 3'd0);
      6'd29: p = ent(SRC_ADJ, ADJ_22, SRC_BX2, 1'b0, 1'b0, DST_DIV, 3'd2);
      6'd30: p = ent(SRC_ADJ, ADJ_02, SRC_BY0, 1'b0, 1'b1, DST_ACC, 3'd0);
      6'd31: p = ent(SRC_ADJ, ADJ_12, SRC_BY1, 1'b0, 1'b0, DST_ACC, 3'd0);
      6'd32: p = ent(SRC_ADJ, ADJ_22, SRC_BY2, 1'b0, 1'b0, DST_DIV, 3'd5);
      6'd33: p = ent(SRC_COEF, 3'd0, SRC_RX, 1'b0, 1'b1, DST_ACC, 3'd0);
      6'd34: p = ent(SRC_COEF, 3'd1, SRC_RY, 1'b0, 1'b0, DST_ACC, 3'd0);
      6'd35: p = ent(SRC_COEF, 3'd2, SRC_ONE, 1'b0, 1'b0, DST_MAPX, 3'd0);
      6'd36: p = ent(SRC_COEF, 3'd3, SRC_RX, 1'b0, 1'b1, DST_ACC, 3'd0);
      6'd37: p = ent(SRC_COEF, 3'd4, SRC_RY, 1'b0, 1'b0, DST_ACC, 3'd0);
      6'd38: p = ent(SRC_COEF, 3'd5, SRC_ONE, 1'b0, 1'b0, DST_MAPY, 3'd0);
      default: p = ent(SRC_ZERO, 3'd0, SRC_ZERO, 1'b0, 1'b1, DST_ACC, 3'd0);
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

/* hdl/touch_affine_calibration_top.sv */
// Touch affine calibration: least-squares fit, Q16.16 coefficients and point mapping.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall  | tac_pkg::in_item_t
//   out     | output    | out_valid / out_stall| tac_pkg::out_item_t
//   cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Add point: one 12x12 product per cycle into the sums.
// Map: runs on the shared 128-bit shift-add unit, one multiplier bit per cycle.
// Solve: 33 shift-add products plus six 33-step divisions share one adder.
// Reset is synchronous and restores identity coefficients; there is no clearing pass.
// in_stall is high while an item is in work; an output stall holds the finished result.
`default_nettype none
module touch_affine_calibration_top #(
  parameter int MAX_POINTS = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire tac_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output tac_pkg::out_item_t     out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [0:0]        cfg_index,
  input  wire logic [11:0]       cfg_data
);
  import tac_pkg::*;

  localparam int PC_W  = $clog2(MAX_POINTS + 1);
  localparam int SRX_W = $clog2(MAX_POINTS * 4095 + 1);
  localparam int STX_W = $clog2(MAX_POINTS * 2047 + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_ADD, ST_LOAD, ST_MUL, ST_TERM, ST_DIV, ST_SAT,
    ST_COEF, ST_ERR, ST_MAP
  } state_t;

  state_t state;

  logic [11:0] screen_width, screen_height;
  logic [PC_W-1:0]  point_count;
  logic             count_overflow;
  logic [31:0]      sum_rx_rx, sum_rx_ry, sum_ry_ry;
  logic [SRX_W-1:0] sum_rx, sum_ry;
  logic [31:0]      sum_rx_tx, sum_ry_tx, sum_rx_ty, sum_ry_ty;
  logic [STX_W-1:0] sum_tx, sum_ty;
  logic signed [31:0] coefficients [6];

  logic [11:0] lrx, lry;
  logic [10:0] ltx, lty;
  logic [2:0]  acnt;
  logic [5:0]  step;
  logic [ACC_W-1:0] acc, mc, dmag, rem, dv;
  logic [ACC_W-1:0] adj [6];
  logic [31:0] mp, q;
  logic        neg, det_neg, qneg, ovf;
  logic [5:0]  dcnt;
  logic [2:0]  ocnt;
  logic [1:0]  err_code;
  logic [10:0] mapped_x, mapped_y;

  prog_t cur;
  logic [ACC_W-1:0] mc_sel, add_a, add_b, add_y;
  logic [31:0] mp_sel, sat_val;
  logic        add_sub;
  logic        accept, out_free, out_load, det_zero, sum_clear, add_ok;
  logic [10:0] lim_x, lim_y;
  logic [23:0] prod;
  logic [11:0] mul_a, mul_b;

  function automatic logic [10:0] axis_lim(logic [11:0] sz);
    if (sz == 12'd0) return 11'd0;
    else if (sz > 12'd2048) return 11'd2047;
    else return 11'(sz - 12'd1);
  endfunction

  function automatic logic [10:0] axis_clamp(logic [ACC_W-1:0] v, logic [10:0] lim);
    if (v[ACC_W-1]) return 11'd0;
    else if (v[ACC_W-2:16] > (ACC_W-17)'(lim)) return lim;
    else return v[26:16];
  endfunction

  assign cur       = prog_step(step);
  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = out_free && (state == ST_COEF || state == ST_ERR || state == ST_MAP);
  assign cfg_ready = 1'b1;
  assign lim_x     = axis_lim(screen_width);
  assign lim_y     = axis_lim(screen_height);
  assign det_zero  = (acc == '0);
  assign add_ok    = !count_overflow && (point_count < PC_W'(MAX_POINTS));

  assign sum_clear =
      (accept && in_data.req_type == REQ_SOLVE &&
       (count_overflow || point_count < PC_W'(MIN_POINTS))) ||
      (state == ST_TERM && cur.dst == DST_DET && det_zero) ||
      (state == ST_SAT && cur.dst_idx == 3'd5);

  always_comb begin
    unique case (cur.mc)
      SRC_A:    mc_sel = ACC_W'(sum_rx_rx);
      SRC_B:    mc_sel = ACC_W'(sum_rx_ry);
      SRC_C:    mc_sel = ACC_W'(sum_rx);
      SRC_D:    mc_sel = ACC_W'(sum_ry_ry);
      SRC_E:    mc_sel = ACC_W'(sum_ry);
      SRC_ADJ:  mc_sel = adj[cur.mc_idx];
      SRC_COEF: mc_sel = {{(ACC_W-32){coefficients[cur.mc_idx][31]}},
                          coefficients[cur.mc_idx]};
      default:  mc_sel = '0;
    endcase
  end

  always_comb begin
    unique case (cur.mp)
      SRC_A:   mp_sel = sum_rx_rx;
      SRC_B:   mp_sel = sum_rx_ry;
      SRC_C:   mp_sel = 32'(sum_rx);
      SRC_D:   mp_sel = sum_ry_ry;
      SRC_E:   mp_sel = 32'(sum_ry);
      SRC_N:   mp_sel = 32'(point_count);
      SRC_BX0: mp_sel = sum_rx_tx;
      SRC_BX1: mp_sel = sum_ry_tx;
      SRC_BX2: mp_sel = 32'(sum_tx);
      SRC_BY0: mp_sel = sum_rx_ty;
      SRC_BY1: mp_sel = sum_ry_ty;
      SRC_BY2: mp_sel = 32'(sum_ty);
      SRC_RX:  mp_sel = 32'(lrx);
      SRC_RY:  mp_sel = 32'(lry);
      SRC_ONE: mp_sel = 32'd1;
      default: mp_sel = 32'd0;
    endcase
  end

  // shared adder/subtractor
  always_comb begin
    unique case (state)
      ST_MUL: begin
        add_a = acc;
        add_b = mc;
        add_sub = neg;
      end
      ST_TERM: begin
        add_a = '0;
        add_b = acc;
        add_sub = acc[ACC_W-1];
      end
      ST_DIV: begin
        add_a = rem;
        add_b = dv;
        add_sub = 1'b1;
      end
      default: begin
        add_a = '0;
        add_b = '0;
        add_sub = 1'b0;
      end
    endcase
    add_y = add_a + (add_b ^ {ACC_W{add_sub}}) + ACC_W'(add_sub);
  end

  always_comb begin
    if (qneg) sat_val = (ovf || q[31]) ? 32'h8000_0000 : (32'd0 - q);
    else      sat_val = (ovf || q[31]) ? 32'h7FFF_FFFF : q;
  end

  always_comb begin
    unique case (acnt)
      3'd0:    begin mul_a = lrx; mul_b = lrx;        end
      3'd1:    begin mul_a = lrx; mul_b = lry;        end
      3'd2:    begin mul_a = lry; mul_b = lry;        end
      3'd3:    begin mul_a = lrx; mul_b = 12'(ltx);   end
      3'd4:    begin mul_a = lry; mul_b = 12'(ltx);   end
      3'd5:    begin mul_a = lrx; mul_b = 12'(lty);   end
      default: begin mul_a = lry; mul_b = 12'(lty);   end
    endcase
    prod = mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= 12'd320;
      screen_height <= 12'd240;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WIDTH:  screen_width  <= cfg_data;
        REG_HEIGHT: screen_height <= cfg_data;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || sum_clear) begin
      point_count <= '0;
      count_overflow <= 1'b0;
      sum_rx_rx <= '0; sum_rx_ry <= '0; sum_ry_ry <= '0;
      sum_rx <= '0; sum_ry <= '0;
      sum_rx_tx <= '0; sum_ry_tx <= '0; sum_tx <= '0;
      sum_rx_ty <= '0; sum_ry_ty <= '0; sum_ty <= '0;
    end else if (accept && in_data.req_type == REQ_ADD) begin
      if (add_ok) begin
        point_count <= point_count + PC_W'(1);
        sum_rx <= sum_rx + SRX_W'(in_data.raw_x);
        sum_ry <= sum_ry + SRX_W'(in_data.raw_y);
        sum_tx <= sum_tx + STX_W'(in_data.target_x);
        sum_ty <= sum_ty + STX_W'(in_data.target_y);
      end else begin
        count_overflow <= 1'b1;
      end
    end else if (state == ST_ADD) begin
      unique case (acnt)
        3'd0:    sum_rx_rx <= sum_rx_rx + 32'(prod);
        3'd1:    sum_rx_ry <= sum_rx_ry + 32'(prod);
        3'd2:    sum_ry_ry <= sum_ry_ry + 32'(prod);
        3'd3:    sum_rx_tx <= sum_rx_tx + 32'(prod);
        3'd4:    sum_ry_tx <= sum_ry_tx + 32'(prod);
        3'd5:    sum_rx_ty <= sum_rx_ty + 32'(prod);
        default: sum_ry_ty <= sum_ry_ty + 32'(prod);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      coefficients[0] <= 32'sd65536;
      coefficients[1] <= '0;
      coefficients[2] <= '0;
      coefficients[3] <= '0;
      coefficients[4] <= 32'sd65536;
      coefficients[5] <= '0;
      acnt <= '0;
      step <= '0;
      dcnt <= '0;
      ocnt <= '0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            lrx <= in_data.raw_x;
            lry <= in_data.raw_y;
            ltx <= in_data.target_x;
            lty <= in_data.target_y;
            unique case (in_data.req_type)
              REQ_ADD: begin
                acnt <= '0;
                if (add_ok) state <= ST_ADD;
              end
              REQ_SOLVE: begin
                if (count_overflow) begin
                  err_code <= ERR_OVERFLOW;
                  state <= ST_ERR;
                end else if (point_count < PC_W'(MIN_POINTS)) begin
                  err_code <= ERR_FEW;
                  state <= ST_ERR;
                end else begin
                  step <= '0;
                  state <= ST_LOAD;
                end
              end
              REQ_MAP: begin
                step <= MAP_START;
                state <= ST_LOAD;
              end
              default: ;
            endcase
          end
        end
        ST_ADD: begin
          acnt <= acnt + 3'd1;
          if (acnt == 3'd6) state <= ST_IDLE;
        end
        ST_LOAD: begin
          if (cur.first) acc <= '0;
          mc <= mc_sel;
          mp <= mp_sel;
          neg <= cur.neg;
          state <= (mp_sel == 32'd0) ? ST_TERM : ST_MUL;
        end
        ST_MUL: begin
          if (mp[0]) acc <= add_y;
          mc <= mc << 1;
          mp <= mp >> 1;
          if (mp[31:1] == 31'd0) state <= ST_TERM;
        end
        ST_TERM: begin
          unique case (cur.dst)
            DST_ACC: begin
              step <= step + 6'd1;
              state <= ST_LOAD;
            end
            DST_ADJ: begin
              adj[cur.dst_idx] <= acc;
              step <= step + 6'd1;
              state <= ST_LOAD;
            end
            DST_DET: begin
              dmag <= add_y;
              det_neg <= acc[ACC_W-1];
              step <= step + 6'd1;
              if (det_zero) begin
                err_code <= ERR_SINGULAR;
                state <= ST_ERR;
              end else begin
                state <= ST_LOAD;
              end
            end
            DST_DIV: begin
              rem <= add_y << 16;
              qneg <= acc[ACC_W-1] ^ det_neg;
              dv <= dmag << 32;
              dcnt <= '0;
              state <= ST_DIV;
            end
            DST_MAPX: begin
              mapped_x <= axis_clamp(acc, lim_x);
              step <= step + 6'd1;
              state <= ST_LOAD;
            end
            default: begin
              mapped_y <= axis_clamp(acc, lim_y);
              state <= ST_MAP;
            end
          endcase
        end
        ST_DIV: begin
          if (dcnt == 6'd0) begin
            ovf <= !add_y[ACC_W-1];
          end else begin
            if (!add_y[ACC_W-1]) rem <= add_y;
            q <= {q[30:0], !add_y[ACC_W-1]};
          end
          dv <= dv >> 1;
          dcnt <= dcnt + 6'd1;
          if (dcnt == 6'd32) state <= ST_SAT;
        end
        ST_SAT: begin
          coefficients[cur.dst_idx] <= sat_val;
          step <= step + 6'd1;
          ocnt <= '0;
          state <= (cur.dst_idx == 3'd5) ? ST_COEF : ST_LOAD;
        end
        ST_COEF: begin
          if (out_free) begin
            out_data.result_kind <= RK_COEF;
            out_data.error_code <= ERR_NONE;
            out_data.mapped_x <= '0;
            out_data.mapped_y <= '0;
            out_data.coef_index <= ocnt;
            out_data.coef_value <= coefficients[ocnt];
            out_data.last <= (ocnt == 3'd5);
            ocnt <= ocnt + 3'd1;
            if (ocnt == 3'd5) state <= ST_IDLE;
          end
        end
        ST_ERR: begin
          if (out_free) begin
            out_data.result_kind <= RK_ERR;
            out_data.error_code <= err_code;
            out_data.mapped_x <= '0;
            out_data.mapped_y <= '0;
            out_data.coef_index <= '0;
            out_data.coef_value <= '0;
            out_data.last <= 1'b1;
            state <= ST_IDLE;
          end
        end
        ST_MAP: begin
          if (out_free) begin
            out_data.result_kind <= RK_MAP;
            out_data.error_code <= ERR_NONE;
            out_data.mapped_x <= mapped_x;
            out_data.mapped_y <= mapped_y;
            out_data.coef_index <= '0;
            out_data.coef_value <= '0;
            out_data.last <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    point_count <= PC_W'(MAX_POINTS))
    else $error("point count beyond limit");

  a_coef_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.result_kind == RK_COEF) |->
      (out_data.last == (out_data.coef_index == 3'd5)))
    else $error("coefficient run closes at wrong index");

  a_map_clamp: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.result_kind == RK_MAP) |->
      (out_data.mapped_x <= lim_x && out_data.mapped_y <= lim_y))
    else $error("mapped transaction outside screen");
`endif
endmodule
`default_nettype wire
